>>> src/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, codes and the state priority table of the status slot picker.
// ----------------------------------------------------------------------------
package ssp_pkg;

   // operation codes carried in the kind field
   localparam logic [2:0] KIND_SET   = 3'd0;
   localparam logic [2:0] KIND_CLEAR = 3'd1;
   localparam logic [2:0] KIND_TOP   = 3'd2;
   localparam logic [2:0] KIND_NEXT  = 3'd3;
   localparam logic [2:0] KIND_READ  = 3'd4;

   // slot state codes
   localparam logic [2:0] SLOT_IDLE      = 3'd0;
   localparam logic [2:0] SLOT_WORKING   = 3'd1;
   localparam logic [2:0] SLOT_NEEDS_YOU = 3'd2;
   localparam logic [2:0] SLOT_REVIEW    = 3'd3;
   localparam logic [2:0] SLOT_FAILED    = 3'd4;
   localparam logic [2:0] SLOT_CELEBRATE = 3'd5;

   localparam logic [2:0] SOURCE_MAX       = 3'd3;
   localparam logic [7:0] PROGRESS_MAX     = 8'd100;
   localparam logic [7:0] PROGRESS_UNKNOWN = 8'd255;
   localparam logic [8:0] PICK_NONE        = 9'h1FF;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_MOD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } fsm_type;

   typedef struct packed {
      logic [2:0]  source;
      logic [2:0]  state;
      logic [7:0]  progress;
      logic [47:0] stamp;
   } rec_type;

   typedef struct packed {
      logic    used;
      rec_type rec;
   } entry_type;

   // last field in the lowest bits
   typedef struct packed {
      logic [5:0]  pad;
      logic [8:0]  current_index;
      logic [47:0] now_time;
      logic [7:0]  progress_in;
      logic [2:0]  state_code;
      logic [2:0]  source_code;
      logic [7:0]  slot_index;
      logic [2:0]  kind;
   } req_type;

   typedef struct packed {
      logic [6:0]  pad;
      logic [47:0] out_time;
      logic [7:0]  out_progress;
      logic [2:0]  out_state;
      logic [2:0]  out_source;
      logic        out_used;
      logic [8:0]  picked_index;
      logic        accepted;
   } rsp_type;

   function automatic logic [2:0] state_rank(input logic [2:0] st);
      logic [2:0] r;
      case (st)
         SLOT_NEEDS_YOU: r = 3'd5;
         SLOT_FAILED:    r = 3'd4;
         SLOT_WORKING:   r = 3'd3;
         SLOT_REVIEW:    r = 3'd2;
         SLOT_CELEBRATE: r = 3'd1;
         default:        r = 3'd0;
      endcase
      return r;
   endfunction

endpackage

>>> src/ssp_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_table
// Slot storage: one synchronous memory for the slot records and a used bit
// per slot in flops. A slot that is not used reads as all zero.
// ----------------------------------------------------------------------------
module ssp_table import ssp_pkg::*; #(
   parameter  int SLOTS = 8,
   localparam int IW    = $clog2(SLOTS)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic          clr_en,
   input  logic [IW-1:0] wr_idx,
   input  rec_type       wr_rec,
   input  logic [IW-1:0] rd_idx,
   output entry_type     rd_ent
);

   rec_type            mem [SLOTS];
   rec_type            rd_rec_ff;
   logic               rd_used_ff;
   logic [SLOTS-1:0]   used_ff;
   logic [SLOTS-1:0]   used_in;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_rec;
      end
      rd_rec_ff <= mem[rd_idx];
   end

   always_comb begin
      used_in = used_ff;
      if (wr_en) begin
         used_in[wr_idx] = 1'b1;
      end else if (clr_en) begin
         used_in[wr_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         rd_used_ff <= 1'b0;
      end else begin
         used_ff    <= used_in;
         rd_used_ff <= used_ff[rd_idx];
      end
   end

   // gate stale records of unused slots
   assign rd_ent = rd_used_ff ? entry_type'{used: 1'b1, rec: rd_rec_ff} : '0;

endmodule

>>> src/status_slot_priority_picker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_slot_priority_picker_top
// Status slot table with set, clear, read, top-priority and round-robin pick.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one operation per beat; rsp_ returns exactly one beat for
//    each, in order.
//  - Set writes the slot record and clear drops its used bit in the accept
//    cycle; ST_EMIT then sends the response. Read adds one memory read.
//  - Top scans every slot through the single memory read port, one slot a
//    cycle. Next first reduces its start index modulo SLOTS with a
//    reciprocal multiply for the quotient, then a subtract for the remainder,
//    and then scans.
//  - One operation is in flight at a time; req_tready is high while the
//    block is idle, which includes while a finished response waits in the
//    output register.
//  - A stalled rsp_ holds its beat; a following operation completes into
//    an internal result register and waits there.
//  - Reset clears every slot to unused and zero within the reset cycle; no
//    clearing pass is needed.
// ----------------------------------------------------------------------------
module status_slot_priority_picker_top import ssp_pkg::*; #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // kind[2:0], slot_index[10:3], source_code[13:11], state_code[16:14],
   // progress_in[24:17], now_time[72:25], current_index[81:73], zero pad
   input  logic [87:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accepted[0], picked_index[9:1], out_used[10], out_source[13:11],
   // out_state[16:14], out_progress[24:17], out_time[72:25], zero pad
   output logic [79:0] rsp_tdata
);

   localparam int IW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int MW    = 10;
   localparam int RW    = MW + 1;
   localparam int SH    = MW + $clog2(SLOTS);
   localparam int BIAS  = ((256 + SLOTS - 1) / SLOTS) * SLOTS;
   // rounded-up reciprocal, exact quotient for every MW-bit start value
   localparam int RECIP = ((1 << SH) + SLOTS - 1) / SLOTS;

   req_type    req;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;
   fsm_type    state_ff, state_in;

   logic [2:0]    kind_ff, kind_in;
   logic [8:0]    cur_ff, cur_in;
   logic          acc_ff, acc_in;
   entry_type     res_ff, res_in;
   logic          found_ff, found_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [2:0]    best_rank_ff, best_rank_in;
   logic [47:0]   best_time_ff, best_time_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] mod_ff, mod_in;
   logic [MW-1:0] quo_ff, quo_in;
   logic          step_ff, step_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;

   logic          accept;
   logic          slot_ok;
   logic          set_ok;
   logic          out_free;
   logic          wr_en, clr_en;
   rec_type       wr_rec;
   logic [IW-1:0] rd_idx;
   entry_type     rd_ent;
   logic          active;
   logic          take;
   logic [2:0]    rank;
   logic [MW+RW-1:0] quo_prod;
   logic [MW+RW-1:0] quo_shift;
   logic [MW-1:0] rem_val;
   logic [10:0]   start_sum;
   logic [7:0]    prog_fix;

   assign req        = req_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign slot_ok    = (req.slot_index < 8'(SLOTS));
   assign set_ok     = slot_ok && (req.state_code <= SLOT_CELEBRATE)
                       && (req.source_code <= SOURCE_MAX);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign prog_fix   = (req.progress_in > PROGRESS_MAX) ? PROGRESS_UNKNOWN
                                                         : req.progress_in;
   assign wr_rec     = rec_type'{source: req.source_code, state: req.state_code,
                                 progress: prog_fix, stamp: req.now_time};
   assign wr_en      = accept && (req.kind == KIND_SET) && set_ok;
   assign clr_en     = accept && (req.kind == KIND_CLEAR) && slot_ok;

   ssp_table #(.SLOTS(SLOTS)) u_table (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (wr_en),
      .clr_en (clr_en),
      .wr_idx (req.slot_index[IW-1:0]),
      .wr_rec (wr_rec),
      .rd_idx (rd_idx),
      .rd_ent (rd_ent)
   );

   // start of next query, biased nonnegative before the modulo
   assign start_sum = $signed({{2{req.current_index[8]}}, req.current_index})
                      + 11'sd1 + 11'(BIAS);
   assign quo_prod  = mod_ff * RW'(RECIP);
   assign quo_shift = quo_prod >> SH;
   assign rem_val   = mod_ff - quo_ff * MW'(SLOTS);

   // candidate check on the slot read in the previous cycle
   assign rank   = state_rank(rd_ent.rec.state);
   assign active = chk_vld_ff && rd_ent.used && (rd_ent.rec.state != SLOT_IDLE);
   always_comb begin
      if (kind_ff == KIND_TOP) begin
         take = active && (!found_ff || (rank > best_rank_ff)
                || ((rank == best_rank_ff) && (rd_ent.rec.stamp >= best_time_ff)));
      end else begin
         take = active && !found_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cur_in       = cur_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rank_in = best_rank_ff;
      best_time_in = best_time_ff;
      ptr_in       = ptr_ff;
      cnt_in       = cnt_ff;
      mod_in       = mod_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      rd_idx       = req.slot_index[IW-1:0];
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (take) begin
         found_in     = 1'b1;
         best_idx_in  = chk_idx_ff;
         best_rank_in = rank;
         best_time_in = rd_ent.rec.stamp;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in      = req.kind;
               cur_in       = req.current_index;
               res_in       = '0;
               found_in     = 1'b0;
               best_idx_in  = '0;
               best_rank_in = '0;
               best_time_in = '0;
               ptr_in       = '0;
               cnt_in       = '0;
               case (req.kind)
                  KIND_SET: begin
                     acc_in   = set_ok;
                     state_in = ST_EMIT;
                  end
                  KIND_CLEAR: begin
                     acc_in   = slot_ok;
                     state_in = ST_EMIT;
                  end
                  KIND_TOP: begin
                     acc_in   = 1'b1;
                     state_in = ST_SCAN;
                  end
                  KIND_NEXT: begin
                     acc_in   = 1'b1;
                     mod_in   = start_sum[MW-1:0];
                     step_in  = 1'b1;
                     state_in = ST_MOD;
                  end
                  KIND_READ: begin
                     acc_in   = slot_ok;
                     state_in = slot_ok ? ST_READ : ST_EMIT;
                  end
                  default: begin
                     acc_in   = 1'b0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in   = rd_ent;
            state_in = ST_EMIT;
         end
         ST_MOD: begin
            // quotient first, then the remainder from it
            if (step_ff) begin
               quo_in  = quo_shift[MW-1:0];
               step_in = 1'b0;
            end else begin
               ptr_in   = rem_val[IW-1:0];
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_idx     = ptr_ff;
            chk_vld_in = 1'b1;
            chk_idx_in = ptr_ff;
            ptr_in     = (ptr_ff == IW'(SLOTS - 1)) ? '0 : ptr_ff + 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CW'(SLOTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in              = '0;
               rsp_in.accepted     = acc_ff;
               rsp_in.out_used     = res_ff.used;
               rsp_in.out_source   = res_ff.rec.source;
               rsp_in.out_state    = res_ff.rec.state;
               rsp_in.out_progress = res_ff.rec.progress;
               rsp_in.out_time     = res_ff.rec.stamp;
               if (kind_ff == KIND_TOP) begin
                  rsp_in.picked_index = found_ff ? 9'(best_idx_ff) : PICK_NONE;
               end else if (kind_ff == KIND_NEXT) begin
                  rsp_in.picked_index = found_ff ? 9'(best_idx_ff) : cur_ff;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         kind_ff      <= '0;
         cnt_ff       <= '0;
         step_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         found_ff     <= found_in;
         kind_ff      <= kind_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      acc_ff       <= acc_in;
      res_ff       <= res_in;
      best_idx_ff  <= best_idx_in;
      best_rank_ff <= best_rank_in;
      best_time_ff <= best_time_in;
      ptr_ff       <= ptr_in;
      mod_ff       <= mod_in;
      quo_ff       <= quo_in;
      chk_idx_ff   <= chk_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 80'(rsp_ff);

endmodule

>>> src/ssp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_checker
// Port-level checks on the status slot picker response stream.
// ----------------------------------------------------------------------------
module ssp_checker import ssp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [79:0] rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata);

   // no response survives reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response dropped or changed");

   // a pick result only comes from a query, which is always accepted
   a_pick_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.picked_index != 9'd0) |-> rsp.accepted)
      else $error("picked index on a rejected response");

   // an unused or rejected read shows an all-zero record
   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp.out_used |-> (rsp.out_state == 3'd0)
      && (rsp.out_source == 3'd0) && (rsp.out_progress == 8'd0)
      && (rsp.out_time == 48'd0))
      else $error("record fields set without used mark");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp.pad == 7'd0) && (rsp.out_used ? rsp.accepted : 1'b1))
      else $error("bad padding or used mark on rejected response");

endmodule

bind status_slot_priority_picker_top ssp_checker u_ssp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the status slot table with set, clear, read, top and next picks.
// A tracker class keeps its own copy of the slot table. It works out the
// response for every accepted request beat and compares each response beat
// field by field, in order. A directed opening covers field extremes, every
// operation, rejects, ties and wrap-around. Random traffic follows, with
// random idle cycles on both channels.
// ----------------------------------------------------------------------------
module testbench;
   import ssp_pkg::*;

   localparam int SLOT_COUNT  = 8;
   localparam int SIW         = $clog2(SLOT_COUNT);
   localparam int RANDOM_OPS  = 1100;
   localparam int STALL_LIMIT = 2000;
   localparam int IDLE_PCT    = 34;
   // operation codes past the last defined one are rejected by the block
   localparam logic [2:0] KIND_UNUSED_LO = KIND_READ + 3'd1;
   localparam logic [2:0] KIND_UNUSED_HI = 3'd7;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;

   bit calm = 1'b0;
   int quiet_cycles = 0;

   class slot_table_tracker;
      bit          used[SLOT_COUNT];
      logic [2:0]  source[SLOT_COUNT];
      logic [2:0]  state[SLOT_COUNT];
      logic [7:0]  progress[SLOT_COUNT];
      logic [47:0] stamp[SLOT_COUNT];
      rsp_type     awaited_replies[$];
      int          fails;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            used[i] = 1'b0;
            source[i] = '0;
            state[i] = SLOT_IDLE;
            progress[i] = '0;
            stamp[i] = '0;
         end
         fails = 0;
      endfunction

      function int urgency(logic [2:0] st);
         case (st)
            SLOT_NEEDS_YOU: return 5;
            SLOT_FAILED:    return 4;
            SLOT_WORKING:   return 3;
            SLOT_REVIEW:    return 2;
            SLOT_CELEBRATE: return 1;
            default:        return 0;
         endcase
      endfunction

      // work out the reply to one request and update the table
      function void note_op(req_type op);
         rsp_type        reply;
         int             best;
         int             best_rank;
         int             idx;
         int             cur;
         logic [47:0]    best_time;
         logic [7:0]     prog;
         logic [SIW-1:0] slot;
         reply = '0;
         slot = op.slot_index[SIW-1:0];
         case (op.kind)
            KIND_SET: begin
               if (op.slot_index < SLOT_COUNT && op.state_code <= SLOT_CELEBRATE &&
                   op.source_code <= SOURCE_MAX) begin
                  prog = op.progress_in;
                  if (prog > PROGRESS_MAX && prog != PROGRESS_UNKNOWN)
                     prog = PROGRESS_UNKNOWN;
                  used[slot] = 1'b1;
                  source[slot] = op.source_code;
                  state[slot] = op.state_code;
                  progress[slot] = prog;
                  stamp[slot] = op.now_time;
                  reply.accepted = 1'b1;
               end
            end
            KIND_CLEAR: begin
               if (op.slot_index < SLOT_COUNT) begin
                  used[slot] = 1'b0;
                  source[slot] = '0;
                  state[slot] = SLOT_IDLE;
                  progress[slot] = '0;
                  stamp[slot] = '0;
                  reply.accepted = 1'b1;
               end
            end
            KIND_TOP: begin
               best = -1;
               best_rank = 0;
               best_time = '0;
               for (int i = 0; i < SLOT_COUNT; i++) begin
                  if (used[i] && state[i] != SLOT_IDLE) begin
                     // later stamp wins a tie, then the higher index
                     if (urgency(state[i]) > best_rank ||
                         (urgency(state[i]) == best_rank && stamp[i] >= best_time)) begin
                        best = i;
                        best_rank = urgency(state[i]);
                        best_time = stamp[i];
                     end
                  end
               end
               reply.accepted = 1'b1;
               reply.picked_index = best[8:0];
            end
            KIND_NEXT: begin
               cur = $signed(op.current_index);
               best = cur;
               for (int k = SLOT_COUNT; k >= 1; k--) begin
                  // walk backward so the first hit after the start wins
                  idx = (cur + k) % SLOT_COUNT;
                  if (idx < 0)
                     idx += SLOT_COUNT;
                  if (used[idx] && state[idx] != SLOT_IDLE)
                     best = idx;
               end
               reply.accepted = 1'b1;
               reply.picked_index = best[8:0];
            end
            KIND_READ: begin
               if (op.slot_index < SLOT_COUNT) begin
                  reply.accepted = 1'b1;
                  reply.out_used = used[slot];
                  reply.out_source = source[slot];
                  reply.out_state = state[slot];
                  reply.out_progress = progress[slot];
                  reply.out_time = stamp[slot];
               end
            end
            default: ;
         endcase
         awaited_replies.push_back(reply);
      endfunction

      function void compare(string name, logic [47:0] want, logic [47:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
         end
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (awaited_replies.size() == 0) begin
            $error("response beat with no request outstanding");
            fails++;
            return;
         end
         want = awaited_replies.pop_front();
         compare("accepted", 48'(want.accepted), 48'(got.accepted));
         compare("picked_index", 48'(want.picked_index), 48'(got.picked_index));
         compare("out_used", 48'(want.out_used), 48'(got.out_used));
         compare("out_source", 48'(want.out_source), 48'(got.out_source));
         compare("out_state", 48'(want.out_state), 48'(got.out_state));
         compare("out_progress", 48'(want.out_progress), 48'(got.out_progress));
         compare("out_time", want.out_time, got.out_time);
      endfunction
   endclass

   slot_table_tracker tracker = new();

   status_slot_priority_picker_top #(
      .SLOTS(SLOT_COUNT)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // check response beats and watch for a hung handshake
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_reply(rsp_type'(rsp_tdata));
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("status_slot_priority_picker_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_op(input req_type op);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= op;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      tracker.note_op(op);
   endtask

   task automatic do_op(input logic [2:0] kind, input logic [7:0] slot,
                        input logic [2:0] src, input logic [2:0] st,
                        input logic [7:0] prog, input logic [47:0] stamp,
                        input logic [8:0] cur);
      req_type op;
      op = '0;
      op.kind = kind;
      op.slot_index = slot;
      op.source_code = src;
      op.state_code = st;
      op.progress_in = prog;
      op.now_time = stamp;
      op.current_index = cur;
      send_op(op);
   endtask

   initial begin
      req_type     op;
      logic [63:0] wide;
      int          roll;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table
      do_op(KIND_READ, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_TOP, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_NEXT, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, -9'sd1);
      // fill, with progress clamping and field extremes
      do_op(KIND_SET, 8'd0, 3'd0, SLOT_WORKING, 8'd0, 48'd0, 9'd0);
      do_op(KIND_SET, 8'd7, SOURCE_MAX, SLOT_NEEDS_YOU, PROGRESS_MAX, '1, 9'd0);
      do_op(KIND_SET, 8'd3, 3'd1, SLOT_FAILED, 8'd101, 48'd5, 9'd0);
      do_op(KIND_SET, 8'd5, 3'd2, SLOT_REVIEW, PROGRESS_UNKNOWN, 48'd5, 9'd0);
      do_op(KIND_SET, 8'd2, 3'd0, SLOT_CELEBRATE, 8'd200, 48'd5, 9'd0);
      do_op(KIND_SET, 8'd1, 3'd0, SLOT_IDLE, 8'd50, 48'd9, 9'd0);
      // rejected sets
      do_op(KIND_SET, 8'd8, 3'd0, SLOT_WORKING, 8'd1, 48'd1, 9'd0);
      do_op(KIND_SET, 8'd255, 3'd0, SLOT_WORKING, 8'd1, 48'd1, 9'd0);
      do_op(KIND_SET, 8'd4, 3'd0, 3'd6, 8'd1, 48'd1, 9'd0);
      do_op(KIND_SET, 8'd4, 3'd0, 3'd7, 8'd1, 48'd1, 9'd0);
      do_op(KIND_SET, 8'd4, 3'd7, SLOT_WORKING, 8'd1, 48'd1, 9'd0);
      // equal priority and stamp: the higher index wins
      do_op(KIND_SET, 8'd4, 3'd0, SLOT_NEEDS_YOU, 8'd1, '1, 9'd0);
      do_op(KIND_TOP, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      // round-robin from several starts, negative ones included
      do_op(KIND_NEXT, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd7);
      do_op(KIND_NEXT, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'h100);
      do_op(KIND_NEXT, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd255);
      do_op(KIND_READ, 8'd3, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_READ, 8'd255, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_CLEAR, 8'd7, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_CLEAR, 8'd200, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_TOP, 8'd0, 3'd0, SLOT_IDLE, 8'd0, 48'd0, 9'd0);
      do_op(KIND_UNUSED_LO, 8'd3, 3'd1, SLOT_WORKING, 8'd1, 48'd1, 9'd1);
      do_op(KIND_UNUSED_HI, 8'd7, 3'd7, 3'd7, 8'd255, '1, 9'h1FF);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         calm = (n >= 500 && n < 700);
         if (n == 300) begin
            // hold off until the block has answered everything
            req_tvalid <= 1'b0;
            while (tracker.awaited_replies.size() != 0)
               @(posedge clock);
         end
         wide = {$urandom, $urandom};
         op = {wide, 24'($urandom)};
         op.pad = '0;
         roll = $urandom_range(0, 99);
         if (roll < 40) begin
            op.kind = KIND_SET;
            if ($urandom_range(0, 99) < 85)
               op.slot_index = 8'($urandom_range(0, SLOT_COUNT - 1));
            if ($urandom_range(0, 99) < 90)
               op.state_code = 3'($urandom_range(SLOT_IDLE, SLOT_CELEBRATE));
            if ($urandom_range(0, 99) < 90)
               op.source_code = 3'($urandom_range(0, SOURCE_MAX));
            case ($urandom_range(0, 3))
               0: op.progress_in = 8'($urandom_range(0, PROGRESS_MAX));
               1: op.progress_in = PROGRESS_UNKNOWN;
               default: ;
            endcase
            // small stamps make ties common
            if ($urandom_range(0, 1) == 0)
               op.now_time = 48'($urandom_range(0, 7));
         end else if (roll < 50) begin
            op.kind = KIND_CLEAR;
            if ($urandom_range(0, 99) < 90)
               op.slot_index = 8'($urandom_range(0, SLOT_COUNT - 1));
         end else if (roll < 65) begin
            op.kind = KIND_TOP;
         end else if (roll < 80) begin
            op.kind = KIND_NEXT;
            case ($urandom_range(0, 4))
               0, 1: op.current_index = -9'sd1;
               2, 3: op.current_index = 9'($urandom_range(0, SLOT_COUNT - 1));
               default: ;
            endcase
         end else if (roll < 96) begin
            op.kind = KIND_READ;
            if ($urandom_range(0, 99) < 90)
               op.slot_index = 8'($urandom_range(0, SLOT_COUNT - 1));
         end else begin
            op.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
         end
         send_op(op);
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      while (tracker.awaited_replies.size() != 0)
         @(posedge clock);
      repeat (SLOT_COUNT + 16) @(posedge clock);
      if (tracker.fails == 0)
         $display("status_slot_priority_picker_top: match");
      else
         $display("status_slot_priority_picker_top: mismatch");
      $finish;
   end

endmodule
